// ----- rtl/core/sbpc_pkg.sv -----
// Shared constants and types for the sectioned bit-vector classifier.
package sbpc_pkg;

    localparam int KEY_BITS_DEF     = 32;
    localparam int NUM_SECTIONS_DEF = 8;
    localparam int MAX_RULES_DEF    = 64;

    localparam int FUNC_W      = 1;
    localparam int RULE_IDX_W  = 6;
    localparam int FIELD_W     = 32;
    localparam int MATCH_W     = 7;

    localparam logic FUNC_WRITE    = 1'b0;
    localparam logic FUNC_CLASSIFY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_LOOK,
        ST_ACC,
        ST_DONE
    } sbpc_state_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic kind;
    } sbpc_stat_t;

endpackage

// ----- rtl/core/sbpc_table_ram.sv -----
// Section table memory: one write port, one registered read port.
module sbpc_table_ram #(
    parameter int DEPTH  = 128,
    parameter int DATA_W = 64,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] table_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/sbpc_seq.sv -----
// Sequencer: table clearing, rule-write read-modify-write walk and classify lookups.
module sbpc_seq #(
    parameter int KEY_BITS     = sbpc_pkg::KEY_BITS_DEF,
    parameter int NUM_SECTIONS = sbpc_pkg::NUM_SECTIONS_DEF,
    parameter int MAX_RULES    = sbpc_pkg::MAX_RULES_DEF,
    parameter int DEPTH        = (NUM_SECTIONS - KEY_BITS % NUM_SECTIONS)
                                 * (1 << (KEY_BITS / NUM_SECTIONS))
                                 + (KEY_BITS % NUM_SECTIONS)
                                 * (1 << (KEY_BITS / NUM_SECTIONS + 1)),
    parameter int ADDR_W       = $clog2(DEPTH)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sbpc_pkg::FUNC_W-1:0]     in_func,
    input  logic [sbpc_pkg::RULE_IDX_W-1:0] in_rule,
    input  logic [sbpc_pkg::FIELD_W-1:0]    in_care,
    input  logic [sbpc_pkg::FIELD_W-1:0]    in_value,
    input  logic [sbpc_pkg::FIELD_W-1:0]    in_key,
    input  logic                            take,
    output sbpc_pkg::sbpc_stat_t            stat,
    output logic [MAX_RULES-1:0]            acc,
    output logic                            wr_en,
    output logic [ADDR_W-1:0]               wr_addr,
    output logic [MAX_RULES-1:0]            wr_data,
    output logic                            rd_en,
    output logic [ADDR_W-1:0]               rd_addr,
    input  logic [MAX_RULES-1:0]            rd_data
);

    localparam int NW         = KEY_BITS / NUM_SECTIONS;
    localparam int NARROW_CNT = NUM_SECTIONS - KEY_BITS % NUM_SECTIONS;
    localparam int SW_MAX     = NW + 1;
    localparam int SEC_W      = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int OFF_W      = $clog2(KEY_BITS);
    localparam int NARROW_SIZE = 1 << NW;
    localparam int WIDE_SIZE   = 1 << SW_MAX;
    localparam logic [SW_MAX-1:0] MASK_WIDE   = '1;
    localparam logic [SW_MAX-1:0] MASK_NARROW = MASK_WIDE >> 1;

    sbpc_pkg::sbpc_state_t state_reg, state_next;
    logic [SEC_W-1:0]  sec_reg,  sec_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [OFF_W-1:0]  off_reg,  off_next;
    logic [SW_MAX-1:0] ent_reg,  ent_next;
    logic [ADDR_W-1:0] clr_reg,  clr_next;
    logic              func_reg, func_next;
    logic [sbpc_pkg::RULE_IDX_W-1:0] rule_reg, rule_next;
    logic [sbpc_pkg::FIELD_W-1:0]    care_reg, care_next;
    logic [sbpc_pkg::FIELD_W-1:0]    val_reg,  val_next;
    logic [sbpc_pkg::FIELD_W-1:0]    key_reg,  key_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              pend_hit_reg, pend_hit_next;
    logic              rdv_reg, rdv_next;
    logic [MAX_RULES-1:0] acc_reg, acc_next;

    logic              wide;
    logic              last_sec;
    logic [SW_MAX-1:0] cur_mask;
    logic [SW_MAX-1:0] cs;
    logic [SW_MAX-1:0] vs;
    logic [SW_MAX-1:0] key_field;
    logic              ent_hit;
    logic              ent_last;
    logic              rule_ok;
    logic [MAX_RULES-1:0] rule_bit;

    assign wide      = {1'b0, sec_reg} >= (SEC_W + 1)'(NARROW_CNT);
    assign last_sec  = sec_reg == SEC_W'(NUM_SECTIONS - 1);
    assign cur_mask  = wide ? MASK_WIDE : MASK_NARROW;
    assign cs        = SW_MAX'(care_reg >> off_reg) & cur_mask;
    assign vs        = SW_MAX'(val_reg >> off_reg) & cs;
    assign key_field = SW_MAX'(key_reg >> off_reg) & cur_mask;
    assign ent_hit   = (ent_reg & cs) == vs;
    assign ent_last  = ent_reg == cur_mask;
    assign rule_ok   = {1'b0, in_rule} < (sbpc_pkg::RULE_IDX_W + 1)'(MAX_RULES);
    assign rule_bit  = MAX_RULES'(1) << rule_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sbpc_pkg::ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            rdv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge aclk) begin
        sec_reg       <= sec_next;
        base_reg      <= base_next;
        off_reg       <= off_next;
        ent_reg       <= ent_next;
        func_reg      <= func_next;
        rule_reg      <= rule_next;
        care_reg      <= care_next;
        val_reg       <= val_next;
        key_reg       <= key_next;
        pend_addr_reg <= pend_addr_next;
        pend_hit_reg  <= pend_hit_next;
        acc_reg       <= acc_next;
    end

    always_comb begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        base_next      = base_reg;
        off_next       = off_reg;
        ent_next       = ent_reg;
        clr_next       = clr_reg;
        func_next      = func_reg;
        rule_next      = rule_reg;
        care_next      = care_reg;
        val_next       = val_reg;
        key_next       = key_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        pend_hit_next  = pend_hit_reg;
        rdv_next       = 1'b0;
        acc_next       = rdv_reg ? (acc_reg & rd_data) : acc_reg;
        rd_en          = 1'b0;
        rd_addr        = base_reg + ADDR_W'(ent_reg);
        wr_en          = pend_reg;
        wr_addr        = pend_addr_reg;
        wr_data        = pend_hit_reg ? (rd_data | rule_bit) : (rd_data & ~rule_bit);
        stat.idle      = 1'b0;
        stat.done      = 1'b0;
        stat.kind      = func_reg;

        case (state_reg)
            sbpc_pkg::ST_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = sbpc_pkg::ST_IDLE;
                end
            end
            sbpc_pkg::ST_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    func_next = in_func;
                    rule_next = in_rule;
                    care_next = in_care;
                    val_next  = in_value;
                    key_next  = in_key;
                    sec_next  = '0;
                    base_next = '0;
                    off_next  = '0;
                    ent_next  = '0;
                    acc_next  = '1;
                    if (in_func == sbpc_pkg::FUNC_CLASSIFY) begin
                        state_next = sbpc_pkg::ST_LOOK;
                    end else if (rule_ok) begin
                        state_next = sbpc_pkg::ST_WALK;
                    end else begin
                        state_next = sbpc_pkg::ST_DONE;
                    end
                end
            end
            sbpc_pkg::ST_WALK: begin
                rd_en          = 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = rd_addr;
                pend_hit_next  = ent_hit;
                if (ent_last) begin
                    ent_next  = '0;
                    sec_next  = sec_reg + SEC_W'(1);
                    base_next = base_reg + (wide ? ADDR_W'(WIDE_SIZE) : ADDR_W'(NARROW_SIZE));
                    off_next  = off_reg + (wide ? OFF_W'(SW_MAX) : OFF_W'(NW));
                    if (last_sec) begin
                        state_next = sbpc_pkg::ST_DRAIN;
                    end
                end else begin
                    ent_next = ent_reg + SW_MAX'(1);
                end
            end
            sbpc_pkg::ST_DRAIN: begin
                state_next = sbpc_pkg::ST_DONE;
            end
            sbpc_pkg::ST_LOOK: begin
                rd_en     = 1'b1;
                rd_addr   = base_reg + ADDR_W'(key_field);
                rdv_next  = 1'b1;
                sec_next  = sec_reg + SEC_W'(1);
                base_next = base_reg + (wide ? ADDR_W'(WIDE_SIZE) : ADDR_W'(NARROW_SIZE));
                off_next  = off_reg + (wide ? OFF_W'(SW_MAX) : OFF_W'(NW));
                if (last_sec) begin
                    state_next = sbpc_pkg::ST_ACC;
                end
            end
            sbpc_pkg::ST_ACC: begin
                state_next = sbpc_pkg::ST_DONE;
            end
            sbpc_pkg::ST_DONE: begin
                stat.done = 1'b1;
                if (take) begin
                    state_next = sbpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbpc_pkg::ST_IDLE;
            end
        endcase
    end

    assign acc = acc_reg;

endmodule

// ----- rtl/core/sectioned_bitvector_packet_classifier_unit.sv -----
// Top level of the sectioned bit-vector ternary packet classifier.
// Input channel s_*: s_func selects a rule write (0) or a key classification (1).
// A rule write updates that rule's bit in every entry of every section table and
// returns m_kind = 0 with m_matched_rule = 0. A classification returns m_kind = 1
// and the index+1 of the lowest-numbered matching rule, or 0 when none matches.
// One item is processed at a time. A classification does one table read per
// section on the single memory read port, then folds in the last word, then
// loads the result.
// A rule write does one read-modify-write per table entry, DEPTH entries over
// all section tables (128 by default), then the last write-back and the
// result load.
// After reset all DEPTH table entries are zeroed one entry per cycle, with
// s_ready low; no rule matches until written.
// The result sits in an output register; the block returns to idle in the cycle
// after the result loads and takes the next item while the result waits.
// If m_ready stays low, a second finished result holds inside the block and
// s_ready stays low until the output register frees.
module sectioned_bitvector_packet_classifier_unit #(
    parameter int KEY_BITS     = sbpc_pkg::KEY_BITS_DEF,
    parameter int NUM_SECTIONS = sbpc_pkg::NUM_SECTIONS_DEF,
    parameter int MAX_RULES    = sbpc_pkg::MAX_RULES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sbpc_pkg::FUNC_W-1:0]     s_func,
    input  logic [sbpc_pkg::RULE_IDX_W-1:0] s_rule_index,
    input  logic [sbpc_pkg::FIELD_W-1:0]    s_care_mask,
    input  logic [sbpc_pkg::FIELD_W-1:0]    s_match_value,
    input  logic [sbpc_pkg::FIELD_W-1:0]    s_key,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [sbpc_pkg::MATCH_W-1:0]    m_matched_rule
);

    localparam int NW       = KEY_BITS / NUM_SECTIONS;
    localparam int WIDE_CNT = KEY_BITS % NUM_SECTIONS;
    localparam int DEPTH    = (NUM_SECTIONS - WIDE_CNT) * (1 << NW)
                              + WIDE_CNT * (1 << (NW + 1));
    localparam int ADDR_W   = $clog2(DEPTH);

    sbpc_pkg::sbpc_stat_t stat;
    logic [MAX_RULES-1:0] acc;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [MAX_RULES-1:0] wr_data;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic [MAX_RULES-1:0] rd_data;
    logic                 take;
    logic [sbpc_pkg::MATCH_W-1:0] hit;

    logic                         out_vld_reg, out_vld_next;
    logic                         out_kind_reg, out_kind_next;
    logic [sbpc_pkg::MATCH_W-1:0] out_rule_reg, out_rule_next;

    sbpc_seq #(
        .KEY_BITS     (KEY_BITS),
        .NUM_SECTIONS (NUM_SECTIONS),
        .MAX_RULES    (MAX_RULES),
        .DEPTH        (DEPTH),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && s_ready),
        .in_func  (s_func),
        .in_rule  (s_rule_index),
        .in_care  (s_care_mask),
        .in_value (s_match_value),
        .in_key   (s_key),
        .take     (take),
        .stat     (stat),
        .acc      (acc),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    sbpc_table_ram #(
        .DEPTH  (DEPTH),
        .DATA_W (MAX_RULES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // lowest set bit wins
    always_comb begin
        hit = '0;
        for (int i = MAX_RULES - 1; i >= 0; i--) begin
            if (acc[i]) begin
                hit = sbpc_pkg::MATCH_W'(i + 1);
            end
        end
    end

    assign take = stat.done && (!out_vld_reg || m_ready);

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_kind_next = out_kind_reg;
        out_rule_next = out_rule_reg;
        if (m_ready) begin
            out_vld_next = 1'b0;
        end
        if (take) begin
            out_vld_next  = 1'b1;
            out_kind_next = stat.kind;
            out_rule_next = (stat.kind == sbpc_pkg::FUNC_CLASSIFY) ? hit : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_kind_reg <= out_kind_next;
        out_rule_reg <= out_rule_next;
    end

    assign s_ready        = stat.idle;
    assign m_valid        = out_vld_reg;
    assign m_kind         = out_kind_reg;
    assign m_matched_rule = out_rule_reg;

endmodule

// ----- dv/tb_sectioned_bitvector_packet_classifier_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench: rule writes and key classifications checked against a table predictor.
module tb_sectioned_bitvector_packet_classifier_unit;

    localparam int KEY_BITS     = sbpc_pkg::KEY_BITS_DEF;
    localparam int NUM_SECTIONS = sbpc_pkg::NUM_SECTIONS_DEF;
    localparam int MAX_RULES    = sbpc_pkg::MAX_RULES_DEF;

    localparam int FUNC_W     = sbpc_pkg::FUNC_W;
    localparam int RULE_IDX_W = sbpc_pkg::RULE_IDX_W;
    localparam int FIELD_W    = sbpc_pkg::FIELD_W;
    localparam int MATCH_W    = sbpc_pkg::MATCH_W;

    localparam logic FUNC_WRITE    = sbpc_pkg::FUNC_WRITE;
    localparam logic FUNC_CLASSIFY = sbpc_pkg::FUNC_CLASSIFY;

    localparam int NW         = KEY_BITS / NUM_SECTIONS;
    localparam int WIDE_CNT   = KEY_BITS % NUM_SECTIONS;
    localparam int NARROW_CNT = NUM_SECTIONS - WIDE_CNT;
    localparam int DEPTH      = NARROW_CNT * (1 << NW) + WIDE_CNT * (1 << (NW + 1));

    localparam int N_RANDOM     = 1230;
    localparam int LIMIT        = 1_000_000;
    localparam int DRAIN_CYCLES = DEPTH + 40;
    localparam int LONG_HOLD    = 3 * DEPTH + 200;

    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_MATCH = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]     func;
        logic [RULE_IDX_W-1:0] rule_index;
        logic [FIELD_W-1:0]    care_mask;
        logic [FIELD_W-1:0]    match_value;
        logic [FIELD_W-1:0]    key;
    } cls_item_t;

    typedef struct packed {
        logic               kind;
        logic [MATCH_W-1:0] matched_rule;
    } cls_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func        = '0;
    logic [RULE_IDX_W-1:0] s_rule_index  = '0;
    logic [FIELD_W-1:0]    s_care_mask   = '0;
    logic [FIELD_W-1:0]    s_match_value = '0;
    logic [FIELD_W-1:0]    s_key         = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic                  m_kind;
    logic [MATCH_W-1:0]    m_matched_rule;

    sectioned_bitvector_packet_classifier_unit #(
        .KEY_BITS     (KEY_BITS),
        .NUM_SECTIONS (NUM_SECTIONS),
        .MAX_RULES    (MAX_RULES)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_rule_index   (s_rule_index),
        .s_care_mask    (s_care_mask),
        .s_match_value  (s_match_value),
        .s_key          (s_key),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_matched_rule (m_matched_rule)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [MAX_RULES-1:0] rule_table [DEPTH];
    logic [FIELD_W-1:0]   shadow_care  [MAX_RULES];
    logic [FIELD_W-1:0]   shadow_value [MAX_RULES];
    bit                   shadow_live  [MAX_RULES];

    cls_item_t   packet_q[$];
    cls_result_t match_q[$];

    int n_items    = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int cycle_cnt  = 0;

    function automatic int sect_width(input int s);
        return (s < NARROW_CNT) ? NW : NW + 1;
    endfunction

    function automatic int sect_lsb(input int s);
        return (s < NARROW_CNT) ? s * NW : NARROW_CNT * NW + (s - NARROW_CNT) * (NW + 1);
    endfunction

    function automatic int sect_base(input int s);
        return (s < NARROW_CNT) ? s * (1 << NW)
                                : NARROW_CNT * (1 << NW) + (s - NARROW_CNT) * (1 << (NW + 1));
    endfunction

    function automatic logic [63:0] sect_field(input logic [FIELD_W-1:0] word, input int s);
        logic [63:0] wide;
        wide = '0;
        wide[FIELD_W-1:0] = word;
        if (sect_lsb(s) >= 64) return 64'd0;
        return (wide >> sect_lsb(s)) & ((64'd1 << sect_width(s)) - 64'd1);
    endfunction

    function automatic void apply_rule_write(input cls_item_t it);
        logic [63:0] cs;
        logic [63:0] vs;
        logic [63:0] ev;
        int s;
        int e;
        if (int'(it.rule_index) >= MAX_RULES) return;
        for (s = 0; s < NUM_SECTIONS; s++) begin
            cs = sect_field(it.care_mask, s);
            vs = sect_field(it.match_value, s) & cs;
            for (e = 0; e < (1 << sect_width(s)); e++) begin
                ev = 64'(e);
                rule_table[sect_base(s) + e][it.rule_index] = ((ev & cs) == vs);
            end
        end
    endfunction

    function automatic logic [MATCH_W-1:0] classify_key(input logic [FIELD_W-1:0] key);
        logic [MAX_RULES-1:0] acc;
        logic [MATCH_W-1:0]   hit;
        int s;
        int i;
        acc = '1;
        hit = '0;
        for (s = 0; s < NUM_SECTIONS; s++)
            acc &= rule_table[sect_base(s) + int'(sect_field(key, s))];
        for (i = MAX_RULES - 1; i >= 0; i--)
            if (acc[i]) hit = MATCH_W'(i + 1);
        return hit;
    endfunction

    function automatic cls_result_t predict_result(input cls_item_t it);
        cls_result_t r;
        if (it.func == FUNC_WRITE) begin
            apply_rule_write(it);
            r.kind         = KIND_ACK;
            r.matched_rule = '0;
        end else begin
            r.kind         = KIND_MATCH;
            r.matched_rule = classify_key(it.key);
        end
        return r;
    endfunction

    task automatic push_write(input int idx, input logic [FIELD_W-1:0] care,
                              input logic [FIELD_W-1:0] value);
        cls_item_t it;
        it.func        = FUNC_WRITE;
        it.rule_index  = RULE_IDX_W'(idx);
        it.care_mask   = care;
        it.match_value = value;
        it.key         = $urandom;
        packet_q.push_back(it);
        if (idx < MAX_RULES) begin
            shadow_care[idx]  = care;
            shadow_value[idx] = value;
            shadow_live[idx]  = 1'b1;
        end
    endtask

    task automatic push_classify(input logic [FIELD_W-1:0] key);
        cls_item_t it;
        it.func        = FUNC_CLASSIFY;
        it.rule_index  = RULE_IDX_W'($urandom);
        it.care_mask   = $urandom;
        it.match_value = $urandom;
        it.key         = key;
        packet_q.push_back(it);
    endtask

    function automatic logic [FIELD_W-1:0] rand_care();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return $urandom;
            3: return $urandom & $urandom & $urandom;
            4: return ((1 << NW) - 1) << (NW * $urandom_range(0, NARROW_CNT - 1));
            default: return $urandom & $urandom & $urandom & $urandom;
        endcase
    endfunction

    // Keys mostly aimed at a live rule, sometimes with one random bit flipped, sometimes pure noise.
    function automatic logic [FIELD_W-1:0] rand_key();
        int r;
        logic [FIELD_W-1:0] noise;
        logic [FIELD_W-1:0] k;
        r     = $urandom_range(0, MAX_RULES - 1);
        noise = $urandom;
        if (!shadow_live[r]) return noise;
        k = (shadow_value[r] & shadow_care[r]) | (noise & ~shadow_care[r]);
        case ($urandom_range(0, 3))
            0: return noise;
            1: return k ^ (32'd1 << $urandom_range(0, FIELD_W - 1));
            default: return k;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Sender: bursts of transfers separated by random gaps.
    int        burst_left = 0;
    int        gap_left   = 0;
    cls_item_t drv_item;

    always @(posedge aclk) begin : drive_proc
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                match_q.push_back(predict_result(drv_item));
                n_accepted++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (packet_q.size() > 0) begin
                    drv_item      = packet_q.pop_front();
                    next_valid    = 1'b1;
                    s_func        <= drv_item.func;
                    s_rule_index  <= drv_item.rule_index;
                    s_care_mask   <= drv_item.care_mask;
                    s_match_value <= drv_item.match_value;
                    s_key         <= drv_item.key;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        gap_left   = 0;
                        burst_left = $urandom_range(20, 80);
                    end else begin
                        gap_left   = $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 10);
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // Receiver: stall pattern rotates through four modes, plus one long hold-off.
    int rx_cycle  = 0;
    int rx_xfers  = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin : accept_proc
        logic next_ready;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (m_valid && m_ready) rx_xfers++;
            if (!hold_done && rx_xfers >= 300) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                next_ready = 1'b0;
            end else begin
                case ((rx_cycle / 256) % 4)
                    0: next_ready = 1'b1;
                    1: next_ready = ($urandom_range(0, 1) == 0);
                    2: next_ready = ((rx_cycle % 7) < 3);
                    default: next_ready = ($urandom_range(0, 4) != 0);
                endcase
            end
            m_ready <= next_ready;
        end
    end

    always @(posedge aclk) begin : check_proc
        cls_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (match_q.size() == 0) begin
                report_mismatch("unexpected transfer kind", m_kind, -1);
            end else begin
                want = match_q.pop_front();
                if (m_kind !== want.kind)
                    report_mismatch("kind", m_kind, want.kind);
                if (m_matched_rule !== want.matched_rule)
                    report_mismatch("matched_rule", m_matched_rule, want.matched_rule);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : main_proc
        int i;
        for (i = 0; i < DEPTH; i++) rule_table[i] = '0;
        for (i = 0; i < MAX_RULES; i++) shadow_live[i] = 1'b0;

        // empty tables, wildcard rule, exact rules, rewrite, ignored value bits
        push_classify(32'h0000_0000);
        push_classify(32'hFFFF_FFFF);
        push_write(MAX_RULES - 1, 32'h0000_0000, 32'hFFFF_FFFF);
        push_classify($urandom);
        push_write(0, 32'hFFFF_FFFF, 32'h0000_0000);
        push_classify(32'h0000_0000);
        push_classify(32'hFFFF_FFFF);
        push_write(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_classify(32'hFFFF_FFFF);
        push_write(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_classify(32'h0000_0000);
        push_classify(32'hFFFF_FFFF);
        push_write(5, 32'h0000_FF00, 32'h1234_5678);
        push_classify(32'hAAAA_56AA);
        push_write(MAX_RULES - 1, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
        push_classify(32'h0000_0000);
        push_classify(32'h5A5A_5A5A);
        push_write(32, 32'h0F0F_0F0F, 32'h0000_0000);
        push_classify(32'hF0F0_F0F0);

        for (i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 99) < 15)
                push_write($urandom_range(0, MAX_RULES - 1), rand_care(), $urandom);
            else
                push_classify(rand_key());
        end
        n_items = packet_q.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_items || match_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
